@@ design/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg: shared constants of the priority traffic light sequencer
// Character codes for the update-line parser, timer limits and register
// indexes of the configuration port.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int unsigned REG_W   = 8;
    localparam int unsigned TIMER_W = 16;

    localparam logic [TIMER_W-1:0] TIMER_MAX   = 16'hFFFF;
    localparam logic [TIMER_W-1:0] TIMER_RESET = 16'd20;   // 5 cars * 4 ticks
    localparam logic [REG_W-1:0]   CAR_RESET   = 8'd5;

    localparam logic [REG_W-1:0] TICKS_PER_CAR_RESET = 8'd4;
    localparam logic [REG_W-1:0] EMPTY_GREEN_RESET   = 8'd1;

    localparam logic CFG_TICKS_PER_CAR     = 1'b0;
    localparam logic CFG_EMPTY_GREEN_TICKS = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

endpackage

@@ design/pts_parser.sv @@
// ----------------------------------------------------------------------------
// pts_parser: update-line parser
// Takes serial bytes of comma-separated decimal fields, saturates each at the
// largest count, and on newline commits car and ambulance counts at once.
// ----------------------------------------------------------------------------
module pts_parser #(
    parameter int NUM_QUADRANTS = 4,
    parameter int COUNT_BITS    = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    byte_en,
    input  logic [7:0]                              byte_value,
    output logic                                    ack,
    output logic [NUM_QUADRANTS-1:0][COUNT_BITS-1:0] car_count,
    output logic [NUM_QUADRANTS-1:0][COUNT_BITS-1:0] amb_count
);

    localparam int FIELDS = 2 * NUM_QUADRANTS;
    localparam int IDX_W  = $clog2(FIELDS + 1);
    localparam int ACC_W  = COUNT_BITS + 4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [FIELDS-1:0][COUNT_BITS-1:0]        fields_reg, fields_next;
    logic [NUM_QUADRANTS-1:0][COUNT_BITS-1:0] car_reg, car_next;
    logic [NUM_QUADRANTS-1:0][COUNT_BITS-1:0] amb_reg, amb_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  neg_reg, neg_next;
    logic                  done_reg, done_next;
    logic                  started_reg, started_next;

    logic                  is_newline, is_comma, is_digit, is_blank, is_sign;
    logic [COUNT_BITS-1:0] stored_value;
    logic [ACC_W-1:0]      acc_wide;
    logic                  idx_in_range;
    logic [FIELDS-1:0][COUNT_BITS-1:0] fields_eff;

    assign is_newline   = (byte_value == pts_pkg::CHAR_NEWLINE);
    assign is_comma     = (byte_value == pts_pkg::CHAR_COMMA);
    assign is_digit     = (byte_value >= pts_pkg::CHAR_ZERO) &&
                          (byte_value <= pts_pkg::CHAR_NINE);
    assign is_blank     = (byte_value == pts_pkg::CHAR_SPACE) ||
                          (byte_value == pts_pkg::CHAR_TAB);
    assign is_sign      = (byte_value == pts_pkg::CHAR_PLUS) ||
                          (byte_value == pts_pkg::CHAR_MINUS);
    assign stored_value = neg_reg ? '0 : acc_reg;
    assign idx_in_range = (idx_reg < IDX_W'(FIELDS));

    // acc * 10 + digit
    assign acc_wide = ACC_W'({acc_reg, 3'b000}) + ACC_W'({acc_reg, 1'b0})
                    + ACC_W'(byte_value - pts_pkg::CHAR_ZERO);

    always_comb
    begin
        for (int i = 0; i < FIELDS; i++)
        begin
            fields_eff[i] = (idx_reg == IDX_W'(i)) ? stored_value : fields_reg[i];
        end
    end

    always_comb
    begin
        fields_next  = fields_reg;
        car_next     = car_reg;
        amb_next     = amb_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        neg_next     = neg_reg;
        done_next    = done_reg;
        started_next = started_reg;
        if (byte_en)
        begin
            if (is_newline)
            begin
                for (int i = 0; i < NUM_QUADRANTS; i++)
                begin
                    car_next[i] = fields_eff[i];
                    amb_next[i] = fields_eff[i + NUM_QUADRANTS];
                end
                fields_next  = '0;
                idx_next     = '0;
                acc_next     = '0;
                neg_next     = 1'b0;
                done_next    = 1'b0;
                started_next = 1'b0;
            end
            else if (is_comma)
            begin
                fields_next = fields_eff;
                if (idx_in_range)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                acc_next     = '0;
                neg_next     = 1'b0;
                done_next    = 1'b0;
                started_next = 1'b0;
            end
            else if (!done_reg)
            begin
                if (is_digit)
                begin
                    acc_next     = (acc_wide > ACC_W'(COUNT_MAX)) ? COUNT_MAX
                                                                 : acc_wide[COUNT_BITS-1:0];
                    started_next = 1'b1;
                end
                else if (!started_reg && is_blank)
                begin
                    acc_next = acc_reg;
                end
                else if (!started_reg && is_sign)
                begin
                    neg_next     = (byte_value == pts_pkg::CHAR_MINUS);
                    started_next = 1'b1;
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_reg  <= '0;
            acc_reg     <= '0;
            idx_reg     <= '0;
            neg_reg     <= 1'b0;
            done_reg    <= 1'b0;
            started_reg <= 1'b0;
            for (int i = 0; i < NUM_QUADRANTS; i++)
            begin
                car_reg[i] <= COUNT_BITS'(pts_pkg::CAR_RESET);
                amb_reg[i] <= '0;
            end
        end
        else
        begin
            fields_reg  <= fields_next;
            car_reg     <= car_next;
            amb_reg     <= amb_next;
            acc_reg     <= acc_next;
            idx_reg     <= idx_next;
            neg_reg     <= neg_next;
            done_reg    <= done_next;
            started_reg <= started_next;
        end
    end

    assign ack       = byte_en && is_newline;
    assign car_count = car_reg;
    assign amb_count = amb_reg;

endmodule

@@ design/priority_traffic_light_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// priority_traffic_light_sequencer_unit: round-robin green sequencer
// Each input item is a half-second tick or one serial byte of an update line.
// Every item yields one result item with the lamp state after that item.
//
// Input channel (in_valid / in_stall): action selects tick (0) or byte (1),
// byte_value carries the character. Output channel (out_valid / out_stall):
// green_mask, active_quadrant, priority_hold, ack_line.
// Configuration: cfg_write with cfg_index 0 (ticks per car) or 1 (empty green
// ticks), taken at once; write only while the block is idle.
// Each result is registered before it is shown on the output channel.
// Throughput: one item per cycle while in_stall is low; the state update and
// the green-time multiply are combinational.
// Stall: results go to an output register backed by one skid register, so
// one more item is taken while a result waits; in_stall rises once the skid
// register is full.
// Reset: quadrant 0 green, car counts 5, no ambulances, timer 20 ticks, no
// result pending.
// ----------------------------------------------------------------------------
module priority_traffic_light_sequencer_unit #(
    parameter int NUM_QUADRANTS = 4,
    parameter int COUNT_BITS    = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [7:0]                       byte_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [NUM_QUADRANTS-1:0]         green_mask,
    output logic [$clog2(NUM_QUADRANTS)-1:0] active_quadrant,
    output logic                             priority_hold,
    output logic                             ack_line,
    input  logic                             cfg_write,
    input  logic                             cfg_index,
    input  logic [pts_pkg::REG_W-1:0]        cfg_data
);

    localparam int QW     = $clog2(NUM_QUADRANTS);
    localparam int TW     = pts_pkg::TIMER_W;
    localparam int PROD_W = (COUNT_BITS + 8 > TW) ? COUNT_BITS + 8 : TW;
    localparam int RES_W  = NUM_QUADRANTS + QW + 2;

    logic [pts_pkg::REG_W-1:0] tpc_reg, empty_reg;
    logic [QW-1:0]             quad_reg, quad_next;
    logic [TW-1:0]             timer_reg, timer_next;
    logic                      hold_reg, hold_next;
    logic [RES_W-1:0]          out_reg, skid_reg, res_next;
    logic                      out_valid_reg, skid_valid_reg;

    logic                      accept, out_fire, tick_en, byte_en, ack;
    logic [NUM_QUADRANTS-1:0][COUNT_BITS-1:0] car_count, amb_count;
    logic [QW-1:0]             quad_inc, sel_q;
    logic [COUNT_BITS-1:0]     sel_car, sel_amb;
    logic [PROD_W-1:0]         prod;
    logic [TW-1:0]             green_ticks;

    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign tick_en  = accept && !action;
    assign byte_en  = accept && action;
    assign in_stall = skid_valid_reg;

    pts_parser #(
        .NUM_QUADRANTS (NUM_QUADRANTS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (byte_en),
        .byte_value (byte_value),
        .ack        (ack),
        .car_count  (car_count),
        .amb_count  (amb_count)
    );

    assign quad_inc = (quad_reg == QW'(NUM_QUADRANTS - 1)) ? '0 : quad_reg + 1'b1;
    assign sel_q    = hold_reg ? quad_reg : quad_inc;
    assign sel_car  = car_count[sel_q];
    assign sel_amb  = amb_count[sel_q];
    assign prod     = PROD_W'(sel_car) * PROD_W'(tpc_reg);

    always_comb
    begin
        if (sel_car == '0)
        begin
            green_ticks = TW'(empty_reg);
        end
        else if (prod > PROD_W'(pts_pkg::TIMER_MAX))
        begin
            green_ticks = pts_pkg::TIMER_MAX;
        end
        else
        begin
            green_ticks = prod[TW-1:0];
        end
    end

    always_comb
    begin
        quad_next  = quad_reg;
        timer_next = timer_reg;
        hold_next  = hold_reg;
        if (tick_en)
        begin
            if (hold_reg)
            begin
                if (sel_amb == '0)
                begin
                    hold_next  = 1'b0;
                    timer_next = green_ticks;
                end
            end
            else if (timer_reg > TW'(1))
            begin
                timer_next = timer_reg - 1'b1;
            end
            else
            begin
                quad_next = quad_inc;
                if (sel_amb != '0)
                begin
                    hold_next  = 1'b1;
                    timer_next = '0;
                end
                else
                begin
                    timer_next = green_ticks;
                end
            end
        end
    end

    assign res_next = {NUM_QUADRANTS'(1) << quad_next, quad_next, hold_next, ack};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpc_reg   <= pts_pkg::TICKS_PER_CAR_RESET;
            empty_reg <= pts_pkg::EMPTY_GREEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pts_pkg::CFG_TICKS_PER_CAR:     tpc_reg   <= cfg_data;
                pts_pkg::CFG_EMPTY_GREEN_TICKS: empty_reg <= cfg_data;
                default:                        tpc_reg   <= tpc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_reg  <= '0;
            timer_reg <= pts_pkg::TIMER_RESET;
            hold_reg  <= 1'b0;
        end
        else
        begin
            quad_reg  <= quad_next;
            timer_reg <= timer_next;
            hold_reg  <= hold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign green_mask      = out_reg[RES_W-1 -: NUM_QUADRANTS];
    assign active_quadrant = out_reg[QW+1:2];
    assign priority_hold   = out_reg[1];
    assign ack_line        = out_reg[0];

endmodule

@@ test/tb_priority_traffic_light_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_priority_traffic_light_sequencer_unit: self-checking bench of the sequencer
// A directed script of ticks and update-line bytes, then phases of random
// update lines with ticks and noise under several timing settings. Each
// accepted item is run through a local lamp predictor; every result item is
// checked field by field against the oldest queued expectation. Both sides idle and
// stall at random, and the receiver holds off for a long stretch per phase.
// ----------------------------------------------------------------------------
module tb_priority_traffic_light_sequencer_unit;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   PHASE_ITEMS = 115;
    localparam int   NUM_PHASES  = 6;
    localparam int   LONG_HOLD   = 80;

    // phase 0 keeps the reset timing
    localparam logic [7:0] PHASE_TPC [NUM_PHASES] = '{8'd4, 8'd1, 8'd0, 8'd2, 8'd1, 8'd255};
    localparam logic [7:0] PHASE_EGT [NUM_PHASES] = '{8'd1, 8'd1, 8'd0, 8'd1, 8'd3, 8'd255};

    typedef struct packed {
        logic [3:0] mask;
        logic [1:0] quad;
        logic       hold;
        logic       ack;
    } lamp_t;

    typedef struct packed {
        logic       act;
        logic [7:0] chr;
        logic       typed;
        lamp_t      want;
    } script_row_t;

    localparam lamp_t Q0_IDLE  = '{mask: 4'b0001, quad: 2'd0, hold: 1'b0, ack: 1'b0};
    localparam lamp_t Q0_ACK   = '{mask: 4'b0001, quad: 2'd0, hold: 1'b0, ack: 1'b1};
    localparam lamp_t NO_CHECK = '0;

    localparam int SCRIPT_LEN = 26;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{ACT_TICK, 8'h00,                     1'b1, Q0_IDLE},
        '{ACT_BYTE, 8'h00,                     1'b1, Q0_IDLE},
        '{ACT_BYTE, 8'hFF,                     1'b1, Q0_IDLE},
        '{ACT_BYTE, pts_pkg::CHAR_NEWLINE,     1'b1, Q0_ACK},
        '{ACT_BYTE, pts_pkg::CHAR_SPACE,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_TAB,         1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_MINUS,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_NINE,        1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_COMMA,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_NINE,        1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_NINE,        1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_NINE,        1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_PLUS,        1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_COMMA,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_COMMA,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_PLUS,        1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_ZERO + 8'd3, 1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_COMMA,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_ZERO + 8'd1, 1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_COMMA,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_COMMA,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_COMMA,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_COMMA,       1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_ZERO + 8'd7, 1'b0, NO_CHECK},
        '{ACT_BYTE, pts_pkg::CHAR_NEWLINE,     1'b0, NO_CHECK},
        '{ACT_TICK, 8'hFF,                     1'b1, Q0_IDLE}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      action;
    logic [7:0]                byte_value;
    logic                      out_valid;
    logic                      out_stall;
    logic [3:0]                green_mask;
    logic [1:0]                active_quadrant;
    logic                      priority_hold;
    logic                      ack_line;
    logic                      cfg_write;
    logic                      cfg_index;
    logic [pts_pkg::REG_W-1:0] cfg_data;

    // typed expectation travels with the payload
    logic  row_typed;
    lamp_t row_want;

    // predictor state
    logic [7:0]                  ticks_per_car_r;
    logic [7:0]                  empty_ticks_r;
    logic [7:0]                  cars [4];
    logic [7:0]                  ambulances [4];
    logic [7:0]                  pending_fields [8];
    logic [7:0]                  digit_acc;
    logic [3:0]                  field_pos;
    logic                        is_negative;
    logic                        field_closed;
    logic                        field_open;
    logic [1:0]                  lit_quadrant;
    logic [pts_pkg::TIMER_W-1:0] green_left;
    logic                        held;

    lamp_t lamp_q [$];
    lamp_t predicted_lamp;
    int    fail_count;
    int    results_seen;
    int    items_sent;
    bit    gaps_on;
    bit    long_hold_req;

    priority_traffic_light_sequencer_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .byte_value      (byte_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .green_mask      (green_mask),
        .active_quadrant (active_quadrant),
        .priority_hold   (priority_hold),
        .ack_line        (ack_line),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [pts_pkg::TIMER_W-1:0] green_ticks(input logic [1:0] q);
        int unsigned t;
        if (cars[q] == 8'd0)
            t = 32'(empty_ticks_r);
        else
            t = 32'(cars[q]) * 32'(ticks_per_car_r);
        if (t > 32'(pts_pkg::TIMER_MAX))
            t = 32'(pts_pkg::TIMER_MAX);
        return pts_pkg::TIMER_W'(t);
    endfunction

    function automatic void latch_field();
        if (field_pos < 4'd8)
            pending_fields[field_pos[2:0]] = is_negative ? 8'd0 : digit_acc;
        digit_acc    = 8'd0;
        is_negative  = 1'b0;
        field_closed = 1'b0;
        field_open   = 1'b0;
    endfunction

    function automatic logic take_char(input logic [7:0] c);
        int unsigned v;
        logic        ack;
        ack = 1'b0;
        if (c == pts_pkg::CHAR_NEWLINE)
        begin
            latch_field();
            for (int i = 0; i < 4; i++)
            begin
                cars[i]       = pending_fields[i];
                ambulances[i] = pending_fields[i + 4];
            end
            foreach (pending_fields[i])
                pending_fields[i] = 8'd0;
            field_pos = 4'd0;
            ack = 1'b1;
        end
        else if (c == pts_pkg::CHAR_COMMA)
        begin
            latch_field();
            if (field_pos < 4'd8)
                field_pos = field_pos + 4'd1;
        end
        else if (!field_closed)
        begin
            if (c >= pts_pkg::CHAR_ZERO && c <= pts_pkg::CHAR_NINE)
            begin
                v = 32'(digit_acc) * 10 + 32'(c) - 32'(pts_pkg::CHAR_ZERO);
                digit_acc  = (v > 255) ? 8'd255 : 8'(v);
                field_open = 1'b1;
            end
            else if (!field_open && (c == pts_pkg::CHAR_SPACE || c == pts_pkg::CHAR_TAB))
            begin
                // leading blank
            end
            else if (!field_open && (c == pts_pkg::CHAR_MINUS || c == pts_pkg::CHAR_PLUS))
            begin
                is_negative = (c == pts_pkg::CHAR_MINUS);
                field_open  = 1'b1;
            end
            else
                field_closed = 1'b1;
        end
        return ack;
    endfunction

    function automatic void take_tick();
        if (held)
        begin
            if (ambulances[lit_quadrant] == 8'd0)
            begin
                held       = 1'b0;
                green_left = green_ticks(lit_quadrant);
            end
        end
        else if (green_left > pts_pkg::TIMER_W'(1))
            green_left = green_left - pts_pkg::TIMER_W'(1);
        else
        begin
            lit_quadrant = lit_quadrant + 2'd1;
            if (ambulances[lit_quadrant] != 8'd0)
            begin
                held       = 1'b1;
                green_left = '0;
            end
            else
                green_left = green_ticks(lit_quadrant);
        end
    endfunction

    function automatic lamp_t step_sequencer(input logic act, input logic [7:0] chr);
        lamp_t r;
        logic  ack;
        ack = 1'b0;
        if (act == ACT_BYTE)
            ack = take_char(chr);
        else
            take_tick();
        r.mask = 4'b0001 << lit_quadrant;
        r.quad = lit_quadrant;
        r.hold = held;
        r.ack  = ack;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 50)
            $display("ERROR result %0d: %s", results_seen, msg);
    endtask

    task automatic check_lamps();
        lamp_t want;
        if (lamp_q.size() == 0)
            report_mismatch("result item with nothing expected");
        else
        begin
            want = lamp_q.pop_front();
            if (green_mask !== want.mask)
                report_mismatch($sformatf("green_mask %b, expected %b", green_mask, want.mask));
            if (active_quadrant !== want.quad)
                report_mismatch($sformatf("active_quadrant %0d, expected %0d",
                                          active_quadrant, want.quad));
            if (priority_hold !== want.hold)
                report_mismatch($sformatf("priority_hold %b, expected %b",
                                          priority_hold, want.hold));
            if (ack_line !== want.ack)
                report_mismatch($sformatf("ack_line %b, expected %b", ack_line, want.ack));
        end
        results_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_lamps();
            if (in_valid && !in_stall)
            begin
                predicted_lamp = step_sequencer(action, byte_value);
                lamp_q.push_back(row_typed ? row_want : predicted_lamp);
            end
        end
    end

    // receiver: random stalls, quiet stretches, and one long hold per request
    initial
    begin
        int unsigned n;
        bit          stalls_on;
        out_stall <= 1'b0;
        stalls_on = 1'b1;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                stalls_on = !stalls_on;
            n = stalls_on ? $urandom_range(0, 14) : 0;
            if (long_hold_req)
            begin
                n = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic push_item(input logic act, input logic [7:0] chr,
                             input logic typed, input lamp_t want);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        byte_value <= chr;
        row_typed  <= typed;
        row_want   <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lamp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_timing(input logic [7:0] tpc, input logic [7:0] egt);
        cfg_write <= 1'b1;
        cfg_index <= pts_pkg::CFG_TICKS_PER_CAR;
        cfg_data  <= tpc;
        @(posedge clk);
        cfg_index <= pts_pkg::CFG_EMPTY_GREEN_TICKS;
        cfg_data  <= egt;
        @(posedge clk);
        cfg_write <= 1'b0;
        ticks_per_car_r = tpc;
        empty_ticks_r   = egt;
    endtask

    // one update line: blanks, signs, empty and missing fields, junk, noise,
    // ticks in the middle, and now and then no newline
    task automatic send_update_line(input bit allow_big);
        logic [7:0]  chars [$];
        int unsigned n_fields;
        int unsigned v;
        int unsigned r;
        string       s;
        n_fields = ($urandom_range(0, 7) != 0) ? 8 : $urandom_range(0, 11);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f > 0)
                chars.push_back(pts_pkg::CHAR_COMMA);
            if ($urandom_range(0, 5) == 0)
                chars.push_back($urandom_range(0, 1) ? pts_pkg::CHAR_SPACE
                                                     : pts_pkg::CHAR_TAB);
            r = $urandom_range(0, 11);
            if (r == 0)
                chars.push_back(pts_pkg::CHAR_MINUS);
            else if (r == 1)
                chars.push_back(pts_pkg::CHAR_PLUS);
            r = $urandom_range(0, 15);
            if (f < 4 || f > 7)
                v = (r < 12) ? $urandom_range(0, 3)
                  : (r < 15 || !allow_big) ? $urandom_range(4, 12)
                  : $urandom_range(200, 99999);
            else
                v = (r < 11) ? 0 : (r < 15) ? $urandom_range(1, 3) : $urandom_range(250, 1000);
            if ($urandom_range(0, 15) != 0)
            begin
                s = $sformatf("%0d", v);
                for (int k = 0; k < s.len(); k++)
                    chars.push_back(s[k]);
            end
            if ($urandom_range(0, 9) == 0)
                chars.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) != 0)
            chars.push_back(pts_pkg::CHAR_NEWLINE);
        if ($urandom_range(0, 7) == 0)
            chars.insert($urandom_range(0, chars.size()), 8'($urandom_range(0, 255)));
        for (int k = 0; k < chars.size(); k++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_CHECK);
            push_item(ACT_BYTE, chars[k], 1'b0, NO_CHECK);
        end
    endtask

    initial
    begin
        int target;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        action     <= ACT_TICK;
        byte_value <= 8'd0;
        cfg_write  <= 1'b0;
        cfg_index  <= pts_pkg::CFG_TICKS_PER_CAR;
        cfg_data   <= '0;
        row_typed  <= 1'b0;
        row_want   <= NO_CHECK;
        fail_count    = 0;
        results_seen  = 0;
        items_sent    = 0;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;

        ticks_per_car_r = pts_pkg::TICKS_PER_CAR_RESET;
        empty_ticks_r   = pts_pkg::EMPTY_GREEN_RESET;
        foreach (cars[i])
        begin
            cars[i]       = pts_pkg::CAR_RESET;
            ambulances[i] = 8'd0;
        end
        foreach (pending_fields[i])
            pending_fields[i] = 8'd0;
        digit_acc    = 8'd0;
        field_pos    = 4'd0;
        is_negative  = 1'b0;
        field_closed = 1'b0;
        field_open   = 1'b0;
        lit_quadrant = 2'd0;
        green_left   = pts_pkg::TIMER_RESET;
        held         = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            push_item(SCRIPT[i].act, SCRIPT[i].chr, SCRIPT[i].typed, SCRIPT[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                set_timing(PHASE_TPC[p], PHASE_EGT[p]);
            end
            long_hold_req = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                gaps_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 7) == 0)
                    push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'b0, NO_CHECK);
                send_update_line(p == NUM_PHASES - 1);
                repeat ($urandom_range(0, 16))
                    push_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_CHECK);
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
